[rtl/cvh_pkg.sv]
package cvh_pkg;

  localparam int MAX_POINTS_DEF  = 64;
  localparam int COORD_WIDTH_DEF = 16;
  // hull_size field width, fixed
  localparam int SIZE_W          = 7;

endpackage

[rtl/cvh_ram.sv]
module cvh_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/convex_hull_graham_scan.sv]
// Graham-scan convex hull. Points go in one per word with tuser = 0 (accepted
// back to back while idle, up to MAX_POINTS kept; extra points are dropped and
// reported in the overflowed bit). A word with tuser = 1 runs the hull: the input
// stalls while a sequencer walks the point memory around a single shared
// multiplier: it finds the anchor, insertion-sorts the points by polar angle
// (nearer first on a collinear tie, O(n^2) compares worst case), keeps the
// farthest point of each direction, runs the stack test on each one left and
// does an O(h^2) sort of the hull by x then y, then sends one hull vertex per
// output word, tlast on the final one. With fewer than three points after that
// removal a single word with tuser = 1 (no hull) is sent. The store is empty afterwards.
module convex_hull_graham_scan
#(
  parameter int MAX_POINTS  = cvh_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = cvh_pkg::COORD_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // x_coord, y_coord
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // cmd
  input  logic s_axis_tuser_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // hull_x, hull_y, hull_size, overflowed
  output logic [((2*COORD_WIDTH+cvh_pkg::SIZE_W+1+7)/8)*8-1:0] m_axis_tdata_o,
  // no_hull
  output logic m_axis_tuser_o,
  output logic m_axis_tlast_o
);
  import cvh_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int PW   = 2 * CW + 3;
  localparam int OTW  = ((2*CW+SIZE_W+1+7)/8)*8;

  localparam logic [5:0] S_IDLE = 6'd0,  S_AN_RD = 6'd1,  S_AN_CMP = 6'd2,
    S_SW0 = 6'd3, S_SW1 = 6'd4, S_SW2 = 6'd5, S_SO_KEY = 6'd6, S_SO_KL = 6'd7,
    S_SO_RD = 6'd8, S_SO_CMP = 6'd9, S_ORA = 6'd10, S_ORB = 6'd11, S_RES = 6'd12,
    S_D1 = 6'd13, S_D2 = 6'd14, S_D3 = 6'd15, S_D4 = 6'd16, S_SO_PUT = 6'd17,
    S_FI_A = 6'd18, S_FI_B = 6'd19, S_FI_C = 6'd20, S_FI_D = 6'd21,
    S_FI_END = 6'd22, S_HI_RD = 6'd23, S_HI_WR = 6'd24, S_HU_RD = 6'd25,
    S_HU_LD = 6'd26, S_HU_CHK = 6'd27, S_HU_POP = 6'd28, S_HU_PUSH = 6'd29,
    S_HS_KEY = 6'd30, S_HS_KL = 6'd31, S_HS_RD = 6'd32, S_HS_CMP = 6'd33,
    S_HS_PUT = 6'd34, S_EM_RD = 6'd35, S_EM_LD = 6'd36, S_EM_WT = 6'd37,
    S_NH = 6'd38;

  localparam logic [1:0] PH_SORT = 2'd0, PH_FILT = 2'd1, PH_HULL = 2'd2;

  logic [5:0] state_q, state_d;
  logic [1:0] ph_q, ph_d;
  logic [CNTW-1:0] cnt_q, cnt_d, n_q, n_d, i_q, i_d, j_q, j_d, m_q, m_d;
  logic [CNTW-1:0] dep_q, dep_d, lo_q, lo_d;
  logic drop_q, drop_d, ovf_q, ovf_d, dd_q, dd_d, ovalid_q, ovalid_d;

  logic signed [CW-1:0] ax_q, ax_d, ay_q, ay_d;
  logic signed [CW-1:0] o0x_q, o0x_d, o0y_q, o0y_d, o1x_q, o1x_d, o1y_q, o1y_d;
  logic signed [CW-1:0] o2x_q, o2x_d, o2y_q, o2y_d;
  logic signed [CW-1:0] tx_q, tx_d, ty_q, ty_d, sx_q, sx_d, sy_q, sy_d;
  logic signed [CW-1:0] ox_q, ox_d, oy_q, oy_d;
  logic [SIZE_W-1:0] osz_q, osz_d;
  logic olast_q, olast_d, onh_q, onh_d;
  logic signed [PW-1:0] pa_q, pa_d, pb_q, pb_d;

  logic signed [CW:0] ma, mb;
  logic signed [2*CW+1:0] prod;

  logic pt_we, sk_we;
  logic [IW-1:0] pt_wa, pt_ra, sk_wa, sk_ra;
  logic [2*CW-1:0] pt_wd, pt_rd, sk_wd, sk_rd;
  logic signed [CW-1:0] prx, pry, skx, sky;
  logic in_acc;

  function automatic logic signed [CW:0] dif(logic signed [CW-1:0] a,
                                             logic signed [CW-1:0] b);
    dif = {a[CW-1], a} - {b[CW-1], b};
  endfunction

  cvh_ram #(.Width(2*CW), .Depth(MAX_POINTS)) u_pt_ram (
    .clk_i, .we_i(pt_we), .waddr_i(pt_wa), .wdata_i(pt_wd),
    .raddr_i(pt_ra), .rdata_o(pt_rd)
  );

  cvh_ram #(.Width(2*CW), .Depth(MAX_POINTS)) u_stk_ram (
    .clk_i, .we_i(sk_we), .waddr_i(sk_wa), .wdata_i(sk_wd),
    .raddr_i(sk_ra), .rdata_o(sk_rd)
  );

  assign prx = pt_rd[CW-1:0];
  assign pry = pt_rd[2*CW-1:CW];
  assign skx = sk_rd[CW-1:0];
  assign sky = sk_rd[2*CW-1:CW];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid_i & s_axis_tready_o;

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      S_ORA:   begin ma = dif(o1y_q, o0y_q); mb = dif(o2x_q, o1x_q); end
      S_ORB:   begin ma = dif(o1x_q, o0x_q); mb = dif(o2y_q, o1y_q); end
      S_D1:    begin ma = dif(o1x_q, o0x_q); mb = ma; end
      S_D2:    begin ma = dif(o1y_q, o0y_q); mb = ma; end
      S_D3:    begin ma = dif(o2x_q, o0x_q); mb = ma; end
      S_D4:    begin ma = dif(o2y_q, o0y_q); mb = ma; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod = ma * mb;

  always_comb begin
    state_d = state_q; ph_d = ph_q; cnt_d = cnt_q; n_d = n_q; i_d = i_q; j_d = j_q;
    m_d = m_q; dep_d = dep_q; lo_d = lo_q; drop_d = drop_q; ovf_d = ovf_q;
    dd_d = dd_q; ovalid_d = ovalid_q;
    ax_d = ax_q; ay_d = ay_q; o0x_d = o0x_q; o0y_d = o0y_q; o1x_d = o1x_q;
    o1y_d = o1y_q; o2x_d = o2x_q; o2y_d = o2y_q; tx_d = tx_q; ty_d = ty_q;
    sx_d = sx_q; sy_d = sy_q; ox_d = ox_q; oy_d = oy_q; osz_d = osz_q;
    olast_d = olast_q; onh_d = onh_q; pa_d = pa_q; pb_d = pb_q;
    pt_we = 1'b0; pt_wa = '0; pt_wd = '0; pt_ra = '0;
    sk_we = 1'b0; sk_wa = '0; sk_wd = '0; sk_ra = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!s_axis_tuser_i) begin
            if (cnt_q < CNTW'(MAX_POINTS)) begin
              pt_we = 1'b1;
              pt_wa = cnt_q[IW-1:0];
              pt_wd = s_axis_tdata_i[2*CW-1:0];
              cnt_d = cnt_q + 1'b1;
            end else begin
              drop_d = 1'b1;
            end
          end else begin
            ovf_d  = drop_q;
            drop_d = 1'b0;
            n_d    = cnt_q;
            cnt_d  = '0;
            i_d    = '0;
            state_d = (cnt_q < CNTW'(3)) ? S_NH : S_AN_RD;
          end
        end
      end
      S_AN_RD: begin
        pt_ra = i_q[IW-1:0];
        state_d = S_AN_CMP;
      end
      S_AN_CMP: begin
        if (i_q == '0 || pry < ay_q || (pry == ay_q && prx < ax_q)) begin
          ax_d = prx; ay_d = pry; lo_d = i_q;
        end
        i_d = i_q + 1'b1;
        state_d = (i_q == n_q - 1'b1) ? S_SW0 : S_AN_RD;
      end
      S_SW0: begin
        pt_ra = '0;
        state_d = S_SW1;
      end
      S_SW1: begin
        pt_we = 1'b1; pt_wa = lo_q[IW-1:0]; pt_wd = pt_rd;
        state_d = S_SW2;
      end
      S_SW2: begin
        pt_we = 1'b1; pt_wa = '0; pt_wd = {ay_q, ax_q};
        i_d = CNTW'(2);
        ph_d = PH_SORT;
        state_d = S_SO_KEY;
      end
      S_SO_KEY: begin
        pt_ra = i_q[IW-1:0];
        state_d = S_SO_KL;
      end
      S_SO_KL: begin
        o0x_d = ax_q; o0y_d = ay_q; o1x_d = prx; o1y_d = pry; j_d = i_q;
        state_d = S_SO_RD;
      end
      S_SO_RD: begin
        pt_ra = IW'(j_q - 1'b1);
        state_d = S_SO_CMP;
      end
      S_SO_CMP: begin
        o2x_d = prx; o2y_d = pry; dd_d = 1'b0;
        state_d = S_ORA;
      end
      S_ORA: begin
        pa_d = PW'(prod);
        state_d = S_ORB;
      end
      S_ORB: begin
        pb_d = PW'(prod);
        state_d = S_RES;
      end
      S_D1: begin pa_d = PW'(prod); state_d = S_D2; end
      S_D2: begin pa_d = pa_q + PW'(prod); state_d = S_D3; end
      S_D3: begin pb_d = PW'(prod); state_d = S_D4; end
      S_D4: begin pb_d = pb_q + PW'(prod); state_d = S_RES; end
      S_RES: begin
        unique case (ph_q)
          PH_SORT: begin
            if (pa_q == pb_q && !dd_q) begin
              // collinear with anchor: nearer first
              dd_d = 1'b1;
              state_d = S_D1;
            end else if (pa_q < pb_q) begin
              pt_we = 1'b1; pt_wa = j_q[IW-1:0]; pt_wd = {o2y_q, o2x_q};
              j_d = j_q - 1'b1;
              state_d = (j_q > CNTW'(2)) ? S_SO_RD : S_SO_PUT;
            end else begin
              state_d = S_SO_PUT;
            end
          end
          PH_FILT: begin
            if (pa_q != pb_q) begin
              pt_we = 1'b1; pt_wa = m_q[IW-1:0]; pt_wd = {o1y_q, o1x_q};
              m_d = m_q + 1'b1;
            end
            o1x_d = o2x_q; o1y_d = o2y_q;
            i_d = i_q + 1'b1;
            state_d = S_FI_C;
          end
          PH_HULL: begin
            if (pa_q < pb_q) begin
              state_d = S_HU_PUSH;
            end else begin
              dep_d = dep_q - 1'b1;
              tx_d = sx_q; ty_d = sy_q;
              sk_ra = IW'(dep_q - CNTW'(3));
              state_d = S_HU_POP;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SO_PUT: begin
        pt_we = 1'b1; pt_wa = j_q[IW-1:0]; pt_wd = {o1y_q, o1x_q};
        i_d = i_q + 1'b1;
        if (i_q == n_q - 1'b1) begin
          state_d = S_FI_A;
        end else begin
          state_d = S_SO_KEY;
        end
      end
      S_FI_A: begin
        pt_ra = IW'(1);
        i_d = CNTW'(1); m_d = CNTW'(1);
        ph_d = PH_FILT;
        state_d = S_FI_B;
      end
      S_FI_B: begin
        o0x_d = ax_q; o0y_d = ay_q; o1x_d = prx; o1y_d = pry;
        state_d = S_FI_C;
      end
      S_FI_C: begin
        if (i_q == n_q - 1'b1) begin
          pt_we = 1'b1; pt_wa = m_q[IW-1:0]; pt_wd = {o1y_q, o1x_q};
          m_d = m_q + 1'b1;
          state_d = S_FI_END;
        end else begin
          pt_ra = IW'(i_q + 1'b1);
          state_d = S_FI_D;
        end
      end
      S_FI_D: begin
        o2x_d = prx; o2y_d = pry;
        state_d = S_ORA;
      end
      S_FI_END: begin
        i_d = '0;
        state_d = (m_q < CNTW'(3)) ? S_NH : S_HI_RD;
      end
      S_HI_RD: begin
        pt_ra = i_q[IW-1:0];
        state_d = S_HI_WR;
      end
      S_HI_WR: begin
        sk_we = 1'b1; sk_wa = i_q[IW-1:0]; sk_wd = pt_rd;
        sx_d = tx_q; sy_d = ty_q; tx_d = prx; ty_d = pry;
        i_d = i_q + 1'b1;
        if (i_q == CNTW'(2)) begin
          dep_d = CNTW'(3);
          ph_d = PH_HULL;
          state_d = S_HU_RD;
        end else begin
          state_d = S_HI_RD;
        end
      end
      S_HU_RD: begin
        if (i_q == m_q) begin
          i_d = CNTW'(1);
          state_d = S_HS_KEY;
        end else begin
          pt_ra = i_q[IW-1:0];
          state_d = S_HU_LD;
        end
      end
      S_HU_LD: begin
        o2x_d = prx; o2y_d = pry;
        state_d = S_HU_CHK;
      end
      S_HU_CHK: begin
        if (dep_q > CNTW'(2)) begin
          o0x_d = sx_q; o0y_d = sy_q; o1x_d = tx_q; o1y_d = ty_q;
          state_d = S_ORA;
        end else begin
          state_d = S_HU_PUSH;
        end
      end
      S_HU_POP: begin
        sx_d = skx; sy_d = sky;
        state_d = S_HU_CHK;
      end
      S_HU_PUSH: begin
        sk_we = 1'b1; sk_wa = dep_q[IW-1:0]; sk_wd = {o2y_q, o2x_q};
        sx_d = tx_q; sy_d = ty_q; tx_d = o2x_q; ty_d = o2y_q;
        dep_d = dep_q + 1'b1;
        i_d = i_q + 1'b1;
        state_d = S_HU_RD;
      end
      S_HS_KEY: begin
        if (i_q == dep_q) begin
          i_d = '0;
          state_d = S_EM_RD;
        end else begin
          sk_ra = i_q[IW-1:0];
          state_d = S_HS_KL;
        end
      end
      S_HS_KL: begin
        o1x_d = skx; o1y_d = sky; j_d = i_q;
        state_d = S_HS_RD;
      end
      S_HS_RD: begin
        sk_ra = IW'(j_q - 1'b1);
        state_d = S_HS_CMP;
      end
      S_HS_CMP: begin
        if (o1x_q < skx || (o1x_q == skx && o1y_q < sky)) begin
          sk_we = 1'b1; sk_wa = j_q[IW-1:0]; sk_wd = sk_rd;
          j_d = j_q - 1'b1;
          state_d = (j_q > CNTW'(1)) ? S_HS_RD : S_HS_PUT;
        end else begin
          state_d = S_HS_PUT;
        end
      end
      S_HS_PUT: begin
        sk_we = 1'b1; sk_wa = j_q[IW-1:0]; sk_wd = {o1y_q, o1x_q};
        i_d = i_q + 1'b1;
        state_d = S_HS_KEY;
      end
      S_EM_RD: begin
        sk_ra = i_q[IW-1:0];
        state_d = S_EM_LD;
      end
      S_EM_LD: begin
        ox_d = skx; oy_d = sky;
        osz_d = SIZE_W'(dep_q);
        olast_d = (i_q == dep_q - 1'b1);
        onh_d = 1'b0;
        ovalid_d = 1'b1;
        state_d = S_EM_WT;
      end
      S_NH: begin
        ox_d = '0; oy_d = '0; osz_d = '0; olast_d = 1'b1; onh_d = 1'b1;
        ovalid_d = 1'b1;
        state_d = S_EM_WT;
      end
      S_EM_WT: begin
        if (ovalid_q && m_axis_tready_i) begin
          ovalid_d = 1'b0;
          i_d = i_q + 1'b1;
          state_d = olast_q ? S_IDLE : S_EM_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      drop_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      drop_q   <= drop_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ph_q <= ph_d; n_q <= n_d; i_q <= i_d; j_q <= j_d; m_q <= m_d;
    dep_q <= dep_d; lo_q <= lo_d; ovf_q <= ovf_d; dd_q <= dd_d;
    ax_q <= ax_d; ay_q <= ay_d;
    o0x_q <= o0x_d; o0y_q <= o0y_d; o1x_q <= o1x_d; o1y_q <= o1y_d;
    o2x_q <= o2x_d; o2y_q <= o2y_d;
    tx_q <= tx_d; ty_q <= ty_d; sx_q <= sx_d; sy_q <= sy_d;
    ox_q <= ox_d; oy_q <= oy_d; osz_q <= osz_d; olast_q <= olast_d; onh_q <= onh_d;
    pa_q <= pa_d; pb_q <= pb_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = OTW'({ovf_q, osz_q, oy_q, ox_q});
  assign m_axis_tuser_o  = onh_q;
  assign m_axis_tlast_o  = olast_q;

endmodule

[dv/convex_hull_graham_scan_tb.sv]
`timescale 1ns / 1ps

module convex_hull_graham_scan_tb;

  localparam int NPTS = cvh_pkg::MAX_POINTS_DEF;
  localparam int CW_W = cvh_pkg::COORD_WIDTH_DEF;
  localparam int SDW  = ((2*CW_W+7)/8)*8;
  localparam int MDW  = ((2*CW_W+cvh_pkg::SIZE_W+1+7)/8)*8;

  localparam bit CMD_ADD     = 1'b0;
  localparam bit CMD_COMPUTE = 1'b1;

  localparam int TURN_NONE = 0;
  localparam int TURN_CW   = 1;
  localparam int TURN_CCW  = 2;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic signed [CW_W-1:0]          hx;
    logic signed [CW_W-1:0]          hy;
    logic [cvh_pkg::SIZE_W-1:0]      size;
    logic                            last;
    logic                            no_hull;
    logic                            ovf;
  } vertex_t;

  typedef struct {
    bit                       cmd;
    logic signed [CW_W-1:0]   x;
    logic signed [CW_W-1:0]   y;
    bit                       typed;   // expected no-hull word given below
    bit                       t_ovf;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [SDW-1:0] s_axis_tdata_i = '0;
  logic s_axis_tuser_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [MDW-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;
  logic m_axis_tlast_o;

  always #2 clk_i = ~clk_i;

  convex_hull_graham_scan dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o,
    .m_axis_tlast_o
  );

  // predictor state
  logic signed [CW_W-1:0] pt_x [NPTS];
  logic signed [CW_W-1:0] pt_y [NPTS];
  int      pt_count;
  bit      drop_seen;
  vertex_t hull_q[$];
  vertex_t new_words[$];

  idle_mode_e mode = IDLE_NONE;
  int  hold_left = 0;
  int  errors = 0;
  int  items = 0;
  int  computes = 0;
  int  words_seen = 0;
  int  hulls_seen = 0;
  int  ovf_runs = 0;

  function automatic int turn(longint x0, longint y0, longint x1, longint y1,
                              longint x2, longint y2);
    longint a, b;
    a = (y1 - y0) * (x2 - x1);
    b = (x1 - x0) * (y2 - y1);
    if (a == b) return TURN_NONE;
    return (a > b) ? TURN_CW : TURN_CCW;
  endfunction

  function automatic bit polar_less(longint ax, longint ay, longint x1, longint y1,
                                    longint x2, longint y2);
    int o;
    o = turn(ax, ay, x1, y1, x2, y2);
    if (o == TURN_CCW) return 1'b1;
    if (o == TURN_CW) return 1'b0;
    return ((x1-ax)*(x1-ax) + (y1-ay)*(y1-ay)) < ((x2-ax)*(x2-ax) + (y2-ay)*(y2-ay));
  endfunction

  task automatic predict_hull();
    longint px[NPTS], py[NPTS], hx[NPTS], hy[NPTS];
    longint t, ax, ay;
    int stk[NPTS];
    int n, lo, m, i, j, sp;
    bit ovf;
    vertex_t w;
    ovf = drop_seen;
    n = pt_count;
    pt_count = 0;
    drop_seen = 0;
    m = 0;
    new_words.delete();
    if (n >= 3) begin
      for (i = 0; i < n; i++) begin
        px[i] = pt_x[i];
        py[i] = pt_y[i];
      end
      lo = 0;
      for (i = 1; i < n; i++)
        if (py[i] < py[lo] || (py[i] == py[lo] && px[i] < px[lo])) lo = i;
      t = px[0]; px[0] = px[lo]; px[lo] = t;
      t = py[0]; py[0] = py[lo]; py[lo] = t;
      ax = px[0];
      ay = py[0];
      for (i = 2; i < n; i++)
        for (j = i; j > 1 && polar_less(ax, ay, px[j], py[j], px[j-1], py[j-1]); j--) begin
          t = px[j]; px[j] = px[j-1]; px[j-1] = t;
          t = py[j]; py[j] = py[j-1]; py[j-1] = t;
        end
      // keep only the farthest point along each direction
      m = 1;
      for (i = 1; i < n; i++) begin
        while (i < n-1 && turn(ax, ay, px[i], py[i], px[i+1], py[i+1]) == TURN_NONE) i++;
        px[m] = px[i];
        py[m] = py[i];
        m++;
      end
    end
    if (m < 3) begin
      w = '{hx: '0, hy: '0, size: '0, last: 1'b1, no_hull: 1'b1, ovf: ovf};
      new_words.push_back(w);
      return;
    end
    stk[0] = 0; stk[1] = 1; stk[2] = 2;
    sp = 3;
    for (i = 3; i < m; i++) begin
      while (sp > 2 && turn(px[stk[sp-2]], py[stk[sp-2]], px[stk[sp-1]], py[stk[sp-1]],
                            px[i], py[i]) != TURN_CCW)
        sp--;
      if (sp < NPTS) begin
        stk[sp] = i;
        sp++;
      end
    end
    for (i = 0; i < sp; i++) begin
      hx[i] = px[stk[i]];
      hy[i] = py[stk[i]];
    end
    for (i = 1; i < sp; i++)
      for (j = i; j > 0 && (hx[j] < hx[j-1] || (hx[j] == hx[j-1] && hy[j] < hy[j-1])); j--)
      begin
        t = hx[j]; hx[j] = hx[j-1]; hx[j-1] = t;
        t = hy[j]; hy[j] = hy[j-1]; hy[j-1] = t;
      end
    for (i = 0; i < sp; i++) begin
      w = '{hx: hx[i][CW_W-1:0], hy: hy[i][CW_W-1:0], size: sp[cvh_pkg::SIZE_W-1:0],
            last: (i == sp-1), no_hull: 1'b0, ovf: ovf};
      new_words.push_back(w);
    end
  endtask

  // one word per call; valid stays high across back-to-back words
  task automatic send_word(bit cmd, logic signed [CW_W-1:0] x, logic signed [CW_W-1:0] y,
                           bit typed = 1'b0, bit t_ovf = 1'b0);
    int gap;
    gap = 0;
    if ((mode == IDLE_SEND && $urandom_range(99) < 86) ||
        (mode == IDLE_BOTH && $urandom_range(99) < 9))
      gap = $urandom_range(1, 5);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= '0;
    s_axis_tdata_i[2*CW_W-1:0] <= {y, x};
    do @(posedge clk_i); while (!s_axis_tready_o);
    items++;
    if (cmd == CMD_ADD) begin
      if (pt_count < NPTS) begin
        pt_x[pt_count] = x;
        pt_y[pt_count] = y;
        pt_count++;
      end else begin
        drop_seen = 1'b1;
      end
    end else begin
      computes++;
      if (drop_seen) ovf_runs++;
      predict_hull();
      if (typed)
        hull_q.push_back('{hx: '0, hy: '0, size: '0, last: 1'b1, no_hull: 1'b1, ovf: t_ovf});
      else
        foreach (new_words[i]) hull_q.push_back(new_words[i]);
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (hull_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [CW_W-1:0] pick_coord(int kind);
    logic signed [CW_W-1:0] edges[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    case (kind)
      0: return CW_W'($urandom);
      1: return CW_W'($signed($urandom_range(8)) - 4);
      default: return edges[$urandom_range(6)];
    endcase
  endfunction

  // receiver side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      case (mode)
        IDLE_RECV: m_axis_tready_i <= ($urandom_range(99) >= 86);
        IDLE_BOTH: m_axis_tready_i <= ($urandom_range(99) >= 9);
        default:   m_axis_tready_i <= 1'b1;
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    vertex_t want;
    vertex_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.hx      = m_axis_tdata_o[CW_W-1:0];
      got.hy      = m_axis_tdata_o[2*CW_W-1:CW_W];
      got.size    = m_axis_tdata_o[2*CW_W +: cvh_pkg::SIZE_W];
      got.ovf     = m_axis_tdata_o[2*CW_W+cvh_pkg::SIZE_W];
      got.no_hull = m_axis_tuser_o;
      got.last    = m_axis_tlast_o;
      words_seen++;
      if (hull_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word x=%0d y=%0d size=%0d last=%0b no_hull=%0b ovf=%0b",
                 $time, got.hx, got.hy, got.size, got.last, got.no_hull, got.ovf);
      end else begin
        want = hull_q.pop_front();
        if (want.last && !want.no_hull) hulls_seen++;
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch exp x=%0d y=%0d size=%0d last=%0b no_hull=%0b ovf=%0b",
                   $time, want.hx, want.hy, want.size, want.last, want.no_hull, want.ovf);
          $display("%0t:          got x=%0d y=%0d size=%0d last=%0b no_hull=%0b ovf=%0b",
                   $time, got.hx, got.hy, got.size, got.last, got.no_hull, got.ovf);
        end
      end
    end
  end

  dir_row_t dir_rows[] = '{
    '{CMD_COMPUTE, 0, 0, 1, 0},                       // empty store
    '{CMD_ADD, 5, 5, 0, 0},
    '{CMD_ADD, -3, 7, 0, 0},
    '{CMD_COMPUTE, 0, 0, 1, 0},                       // two points only
    '{CMD_ADD, -32768, -32768, 0, 0},                 // corners of the full range
    '{CMD_ADD, 32767, -32768, 0, 0},
    '{CMD_ADD, 32767, 32767, 0, 0},
    '{CMD_ADD, -32768, 32767, 0, 0},
    '{CMD_ADD, 0, 0, 0, 0},
    '{CMD_ADD, 32767, 32767, 0, 0},                   // duplicate corner
    '{CMD_COMPUTE, 0, 0, 0, 0},
    '{CMD_ADD, 1, 1, 0, 0},                           // all on one line
    '{CMD_ADD, 3, 3, 0, 0},
    '{CMD_ADD, 2, 2, 0, 0},
    '{CMD_ADD, 1, 1, 0, 0},
    '{CMD_COMPUTE, 0, 0, 1, 0},
    '{CMD_ADD, 0, 0, 0, 0},                           // anchor copies, collinear edge
    '{CMD_ADD, 0, 0, 0, 0},
    '{CMD_ADD, 4, 0, 0, 0},
    '{CMD_ADD, 2, 0, 0, 0},
    '{CMD_ADD, 4, 4, 0, 0},
    '{CMD_ADD, 2, 2, 0, 0},
    '{CMD_ADD, 0, 4, 0, 0},
    '{CMD_COMPUTE, 0, 0, 0, 0}
  };

  initial begin
    int set_no, n, kind;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r])
      send_word(dir_rows[r].cmd, dir_rows[r].x, dir_rows[r].y,
                dir_rows[r].typed, dir_rows[r].t_ovf);
    drain();

    set_no = 0;
    while (items < 430) begin
      if (set_no % 4 == 0) begin
        drain();   // quiet point between idle phases
        mode = idle_mode_e'((set_no / 4) % 4);
      end
      case ($urandom_range(11))
        0:       n = $urandom_range(60, 70);   // fill, sometimes overflow
        1:       n = $urandom_range(2);
        default: n = $urandom_range(3, 14);
      endcase
      kind = $urandom_range(2);
      for (int i = 0; i < n; i++)
        send_word(CMD_ADD, pick_coord(kind), pick_coord(kind));
      if (set_no == 5) begin
        // output stall outlasting the longest hull run, points keep coming behind it
        hold_left = 30000;
        send_word(CMD_COMPUTE, 0, 0);
        for (int i = 0; i < 6; i++) send_word(CMD_ADD, pick_coord(0), pick_coord(0));
      end else begin
        send_word(CMD_COMPUTE, 0, 0);
      end
      set_no++;
    end
    send_word(CMD_COMPUTE, 0, 0);
    s_axis_tvalid_i <= 1'b0;

    for (int c = 0; c < 200000 && hull_q.size() != 0; c++) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (hull_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected words never arrived", $time, hull_q.size());
    end
    $display("Sent %0d words with %0d hull runs (%0d with dropped points).",
             items, computes, ovf_runs);
    $display("Checked %0d output words, %0d complete hulls, under four idle patterns.",
             words_seen, hulls_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[files.f]
rtl/cvh_pkg.sv
rtl/cvh_ram.sv
rtl/convex_hull_graham_scan.sv
dv/convex_hull_graham_scan_tb.sv
